// ===== design/mlp_sigmoid_inference_top_macros.svh =====
// ----------------------------------------------------------------------------
// mlp_sigmoid_inference_top_macros
// Assertion macros used by the checker of the inference block.
// ----------------------------------------------------------------------------
`ifndef MLP_SIGMOID_INFERENCE_TOP_MACROS_SVH
`define MLP_SIGMOID_INFERENCE_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define MLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/mlp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared constants, register codes and the sigmoid table of the MLP block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlp_pkg;

  localparam int CFG_LAYERS  = 4;
  localparam int ACC_BITS    = 40;
  localparam int SIG_ENTRIES = 256;
  localparam int SIG_BITS    = 9;
  localparam int ONE_Q88     = 256;
  localparam logic [63:0] E16 = 64'd4034748382;

  typedef enum logic [2:0] {
    CFG_LAYER_COUNT  = 3'd0,
    CFG_INPUT_WIDTH  = 3'd1,
    CFG_WIDTH_ONE    = 3'd2,
    CFG_WIDTH_TWO    = 3'd3,
    CFG_WIDTH_THREE  = 3'd4,
    CFG_WIDTH_FOUR   = 3'd5
  } cfg_idx_e;

  typedef logic [SIG_BITS-1:0] sig_tab_t [SIG_ENTRIES];

  // Clamp a width register to 1..maxw.
  function automatic int clamp_width(logic [3:0] w, int maxw);
    int r;
    r = int'(w);
    if (r == 0) r = 1;
    if (r > maxw) r = maxw;
    return r;
  endfunction

  // Sigmoid samples at z = -8 + i/16, rounded half up; the quotient is
  // found by a bit-by-bit search.
  function automatic sig_tab_t build_sig_table();
    sig_tab_t    t;
    logic [63:0] p [129];
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rhs;
    logic [63:0] trial;
    logic [8:0]  v;
    int          kk;
    p[0] = 64'd1 << 32;
    for (int k = 1; k <= 128; k++) begin
      p[k] = (p[k-1] * E16 + (64'd1 << 31)) >> 32;
    end
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      kk  = (i >= 128) ? i - 128 : 128 - i;
      den = (64'd1 << 32) + p[kk];
      num = (i >= 128) ? (64'd1 << 32) : p[kk];
      rhs = num * 64'd512 + den;
      v   = '0;
      for (int b = 8; b >= 0; b--) begin
        trial = 64'(v | (9'd1 << b)) * (den << 1);
        if (trial <= rhs) v = v | (9'd1 << b);
      end
      t[i] = v;
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

// ===== design/mlp_ram.sv =====
// ----------------------------------------------------------------------------
// mlp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/mlp_sigmoid.sv =====
// ----------------------------------------------------------------------------
// mlp_sigmoid
// Saturating table sigmoid: Q24.16 accumulator in, registered Q1.8 out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlp_sigmoid (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [mlp_pkg::ACC_BITS-1:0]   acc_i,
  output logic [mlp_pkg::SIG_BITS-1:0]          val_o
);

  localparam logic signed [mlp_pkg::ACC_BITS-1:0] Lim = mlp_pkg::ACC_BITS'(8 << 16);

  logic [20:0] shifted;
  logic [7:0]  idx;

  always_comb begin
    shifted = acc_i[20:0] + 21'h080000;
    if (acc_i < -Lim)      idx = 8'd0;
    else if (acc_i >= Lim) idx = 8'd255;
    else                   idx = shifted[19:12];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) val_o <= mlp_pkg::SIG_TABLE[idx];
  end

endmodule

// ===== design/mlp_sigmoid_inference_top.sv =====
// ----------------------------------------------------------------------------
// mlp_sigmoid_inference_top
// Fixed-point multilayer perceptron with a table sigmoid unit.
// ----------------------------------------------------------------------------
// Weight transactions (opcode 0) and feature transactions (opcode 1) are
// accepted whenever the block is idle. A feature marked last starts
// inference: one shared multiply-accumulate unit walks the weight memory,
// one weight per cycle; each neuron issues (inputs + 1) weights, then drains
// the read/multiply pipeline, looks up the sigmoid and writes the activation
// back. The reset sizes are 2 features and layers of 3 and 1 neurons.
// Results of the final layer leave through an output register; if it is
// still full when the next one is ready, the engine holds. Weights and
// activations are kept in synchronous RAMs and come up undefined; load
// every weight that is used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlp_sigmoid_inference_top #(
  parameter int MAX_LAYERS = 4,
  parameter int MAX_WIDTH  = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [1:0]                   layer_sel_i,
  input  logic [2:0]                   neuron_sel_i,
  input  logic [3:0]                   position_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                         last_feature_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   out_index_o,
  output logic [8:0]                   out_value_o,
  output logic                         out_last_o,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_index_i,
  input  logic [3:0]                   cfg_data_i
);

  localparam int WStride  = MAX_WIDTH + 1;
  localparam int WDepth   = MAX_LAYERS * MAX_WIDTH * WStride;
  localparam int WaW      = $clog2(WDepth);
  localparam int ActBits  = (VALUE_BITS > 10) ? VALUE_BITS : 10;
  localparam int ADepth   = 2 * MAX_WIDTH;
  localparam int AaW      = $clog2(ADepth);
  localparam int CntW     = $clog2(MAX_WIDTH + 1);
  localparam int LayW     = $clog2(mlp_pkg::CFG_LAYERS);
  localparam int MaxNl    = (MAX_LAYERS < mlp_pkg::CFG_LAYERS) ? MAX_LAYERS
                                                              : mlp_pkg::CFG_LAYERS;
  localparam int ProdBits = VALUE_BITS + ActBits;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SIG   = 5'b01000,
    ST_WB    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [2:0] layer_count_q;
  logic [3:0] input_width_q;
  logic [3:0] width_q [mlp_pkg::CFG_LAYERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= 3'd2;
      input_width_q <= 4'd2;
      width_q[0]    <= 4'd3;
      width_q[1]    <= 4'd1;
      width_q[2]    <= 4'd1;
      width_q[3]    <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (mlp_pkg::cfg_idx_e'(cfg_index_i))
        mlp_pkg::CFG_LAYER_COUNT: layer_count_q <= cfg_data_i[2:0];
        mlp_pkg::CFG_INPUT_WIDTH: input_width_q <= cfg_data_i;
        mlp_pkg::CFG_WIDTH_ONE:   width_q[0]    <= cfg_data_i;
        mlp_pkg::CFG_WIDTH_TWO:   width_q[1]    <= cfg_data_i;
        mlp_pkg::CFG_WIDTH_THREE: width_q[2]    <= cfg_data_i;
        mlp_pkg::CFG_WIDTH_FOUR:  width_q[3]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer counters.
  logic [LayW-1:0] l_q, l_d;
  logic [CntW-1:0] n_q, n_d, k_q, k_d, nin_q, nin_d, nout_q, nout_d;
  logic [2:0]      nl_q, nl_d;

  // Pipeline: stage 1 has RAM data, stage 2 adds the product.
  logic s1_q, s1_bias_q, s2_q;
  logic signed [ProdBits-1:0]               prod_q, prod_d;
  logic signed [mlp_pkg::ACC_BITS-1:0]      acc_q, acc_d;

  logic signed [VALUE_BITS-1:0] w_rdata;
  logic signed [ActBits-1:0]    a_rdata, a_oper;
  logic [mlp_pkg::SIG_BITS-1:0] sig_val;

  logic in_acc, start, w_we, a_we, final_layer, stall, wb_go, out_load;
  logic [WaW-1:0] w_waddr, w_raddr;
  logic [AaW-1:0] a_waddr, a_raddr;
  logic [ActBits-1:0] a_wdata;
  logic [CntW-1:0] k_idx;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign start      = in_acc && opcode_i && last_feature_i;

  // Weight store port: loads from transactions, reads from the engine.
  assign w_we = in_acc && !opcode_i && (int'(layer_sel_i) < MAX_LAYERS)
                && (int'(neuron_sel_i) < MAX_WIDTH) && (int'(position_i) <= MAX_WIDTH);
  assign w_waddr = WaW'((int'(layer_sel_i) * MAX_WIDTH + int'(neuron_sel_i)) * WStride
                        + int'(position_i));
  assign w_raddr = WaW'((int'(l_q) * MAX_WIDTH + int'(n_q)) * WStride + int'(k_q));

  // Activation port: bank 0 takes features, layers alternate banks.
  assign final_layer = (3'(l_q) == nl_q - 3'd1);
  assign stall       = final_layer && out_valid_o && !out_ready_i;
  assign wb_go       = (state_q == ST_WB) && !stall;
  assign out_load    = wb_go && final_layer;
  assign k_idx       = (k_q == '0) ? '0 : k_q - 1'b1;

  always_comb begin
    a_we    = 1'b0;
    a_waddr = AaW'(position_i);
    a_wdata = ActBits'(value_i);
    if (in_acc && opcode_i && (int'(position_i) < MAX_WIDTH)) begin
      a_we = 1'b1;
    end else if (wb_go) begin
      a_we    = 1'b1;
      a_waddr = AaW'(int'(!l_q[0]) * MAX_WIDTH + int'(n_q));
      a_wdata = ActBits'(sig_val);
    end
  end

  assign a_raddr = AaW'(int'(l_q[0]) * MAX_WIDTH + int'(k_idx));

  mlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(WDepth)) u_wram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (value_i),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  mlp_ram #(.WIDTH(ActBits), .DEPTH(ADepth)) u_aram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mlp_sigmoid u_sig (
    .clk_i (clk_i),
    .en_i  (state_q == ST_SIG),
    .acc_i (acc_q),
    .val_o (sig_val)
  );

  // Multiply-accumulate; the bias position multiplies by 1.0.
  assign a_oper = s1_bias_q ? ActBits'(mlp_pkg::ONE_Q88) : a_rdata;
  assign prod_d = w_rdata * a_oper;

  always_comb begin
    acc_d = acc_q;
    if (state_q == ST_IDLE || wb_go) acc_d = '0;
    else if (s2_q) acc_d = acc_q + mlp_pkg::ACC_BITS'(prod_q);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= 1'b0;
      s1_bias_q <= 1'b0;
      s2_q      <= 1'b0;
    end else begin
      s1_q      <= (state_q == ST_MAC);
      s1_bias_q <= (k_q == '0);
      s2_q      <= s1_q;
    end
  end

  // Sequencer: walk neurons, then layers.
  always_comb begin
    state_d = state_q;
    l_d     = l_q;
    n_d     = n_q;
    k_d     = k_q;
    nin_d   = nin_q;
    nout_d  = nout_q;
    nl_d    = nl_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_MAC;
          l_d     = '0;
          n_d     = '0;
          k_d     = '0;
          nin_d   = CntW'(mlp_pkg::clamp_width(input_width_q, MAX_WIDTH));
          nout_d  = CntW'(mlp_pkg::clamp_width(width_q[0], MAX_WIDTH));
          nl_d    = 3'(mlp_pkg::clamp_width({1'b0, layer_count_q}, MaxNl));
        end
      end
      ST_MAC: begin
        k_d = k_q + 1'b1;
        if (k_q == nin_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1_q && !s2_q) state_d = ST_SIG;
      end
      ST_SIG: state_d = ST_WB;
      ST_WB: begin
        if (!stall) begin
          k_d     = '0;
          state_d = ST_MAC;
          if (n_q == nout_q - 1'b1) begin
            if (final_layer) begin
              state_d = ST_IDLE;
            end else begin
              l_d    = l_q + 1'b1;
              n_d    = '0;
              nin_d  = nout_q;
              nout_d = CntW'(mlp_pkg::clamp_width(width_q[LayW'(l_q + 1'b1)], MAX_WIDTH));
            end
          end else begin
            n_d = n_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      l_q     <= '0;
      n_q     <= '0;
      k_q     <= '0;
      nin_q   <= '0;
      nout_q  <= '0;
      nl_q    <= '0;
    end else begin
      state_q <= state_d;
      l_q     <= l_d;
      n_q     <= n_d;
      k_q     <= k_d;
      nin_q   <= nin_d;
      nout_q  <= nout_d;
      nl_q    <= nl_d;
    end
  end

  // Output register: load a final-layer result, drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_o <= 3'(n_q);
      out_value_o <= sig_val;
      out_last_o  <= (n_q == nout_q - 1'b1);
    end
  end

endmodule

// ===== design/mlp_checker.sv =====
// ----------------------------------------------------------------------------
// mlp_checker
// Port-level assertions for the inference block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mlp_sigmoid_inference_top_macros.svh"

module mlp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_index_i,
  input logic [8:0] out_value_i,
  input logic       out_last_i
);

  logic [12:0] out_bus;

  assign out_bus = {out_index_i, out_value_i, out_last_i};

  `MLP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `MLP_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_bus), "result changed")
  `MLP_ASSERT(a_busy_mid, out_valid_i && out_ready_i && !out_last_i |=> out_valid_i || !in_ready_i, "idle early")
  `MLP_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_i, "result during reset")

endmodule

bind mlp_sigmoid_inference_top mlp_checker u_mlp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_index_i (out_index_o),
  .out_value_i (out_value_o),
  .out_last_i  (out_last_o)
);

// ===== dv/mlp_sigmoid_inference_top_tb.sv =====
// ----------------------------------------------------------------------------
// mlp_sigmoid_inference_top_tb
// Drives weight and feature transactions into the inference block and checks
// every output neuron result against a fixed-point network predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlp_sigmoid_inference_top_tb;

  localparam logic OP_WEIGHT  = 1'b0;
  localparam logic OP_FEATURE = 1'b1;
  localparam int   NLAYERS    = 4;
  localparam int   NWIDTH     = 8;
  localparam int   IDLE_LIMIT = 6000;
  localparam int   DRAIN_GAP  = 16;

  typedef struct packed {
    logic [2:0] index;
    logic [8:0] activation;
    logic       last;
  } neuron_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               opcode_i = 1'b0;
  logic [1:0]         layer_sel_i = '0;
  logic [2:0]         neuron_sel_i = '0;
  logic [3:0]         position_i = '0;
  logic signed [15:0] value_i = '0;
  logic               last_feature_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         out_index_o;
  logic [8:0]         out_value_o;
  logic               out_last_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [3:0]         cfg_data_i = '0;

  mlp_sigmoid_inference_top u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: raw register copies, weights, both activation banks.
  logic [3:0]         reg_val [6];
  logic signed [15:0] weight_mem [NLAYERS][NWIDTH][NWIDTH+1];
  bit                 weight_seen [NLAYERS][NWIDTH][NWIDTH+1];
  logic signed [15:0] act_bank [2][NWIDTH];
  bit                 feature_seen [NWIDTH];
  logic [8:0]         sigmoid_rom [256];

  neuron_result_t     pending_q [$];
  int                 error_count = 0;
  int                 items_sent = 0;
  int                 results_seen = 0;
  int                 inferences = 0;
  int                 idle_cycles = 0;

  // Sender pacing and receiver stall pattern.
  bit                 sender_gaps = 1'b1;
  int                 burst_left = 0;
  int                 rx_mode = 0;
  int                 rx_count = 0;

  function automatic void build_sigmoid();
    longint unsigned p [129];
    longint unsigned num;
    longint unsigned den;
    int              kk;
    p[0] = 64'd1 << 32;
    for (int k = 1; k <= 128; k++) begin
      p[k] = (p[k-1] * 64'd4034748382 + (64'd1 << 31)) >> 32;
    end
    for (int i = 0; i < 256; i++) begin
      kk  = (i >= 128) ? i - 128 : 128 - i;
      den = (64'd1 << 32) + p[kk];
      num = (i >= 128) ? (64'd1 << 32) : p[kk];
      sigmoid_rom[i] = 9'((num * 64'd512 + den) / (64'd2 * den));
    end
  endfunction

  function automatic int eff_width(logic [3:0] w);
    if (w == 0) return 1;
    if (w > NWIDTH) return NWIDTH;
    return int'(w);
  endfunction

  function automatic int eff_layers();
    if (reg_val[mlp_pkg::CFG_LAYER_COUNT] == 0) return 1;
    if (reg_val[mlp_pkg::CFG_LAYER_COUNT] > NLAYERS) return NLAYERS;
    return int'(reg_val[mlp_pkg::CFG_LAYER_COUNT]);
  endfunction

  function automatic int layer_neurons(int l);
    return eff_width(reg_val[mlp_pkg::CFG_WIDTH_ONE + l]);
  endfunction

  // Run the network on bank 0 and queue one result per final neuron.
  function automatic void predict_network();
    int                nl;
    int                nin;
    int                nout;
    int                src;
    longint            acc;
    logic [39:0]       acc40;
    longint            z;
    int                idx;
    neuron_result_t    r;
    nl  = eff_layers();
    nin = eff_width(reg_val[mlp_pkg::CFG_INPUT_WIDTH]);
    src = 0;
    nout = 0;
    for (int l = 0; l < nl; l++) begin
      nout = layer_neurons(l);
      for (int n = 0; n < nout; n++) begin
        acc = longint'(weight_mem[l][n][0]) * 256;
        for (int k = 0; k < nin; k++) begin
          acc += longint'(act_bank[src][k]) * longint'(weight_mem[l][n][k+1]);
        end
        acc40 = acc[39:0];
        z = longint'(signed'(acc40));
        if (z < -(64'sd8 << 16)) idx = 0;
        else if (z >= (64'sd8 << 16)) idx = 255;
        else idx = int'((z + (64'sd8 << 16)) >>> 12) & 255;
        act_bank[1-src][n] = 16'(sigmoid_rom[idx]);
      end
      src = 1 - src;
      nin = nout;
    end
    // Even layer counts leave fresh values in the feature bank.
    if (src == 0) begin
      for (int n = 0; n < nout; n++) feature_seen[n] = 1'b1;
    end
    for (int n = 0; n < nout; n++) begin
      r.index      = 3'(n);
      r.activation = act_bank[src][n][8:0];
      r.last       = (n == nout - 1);
      pending_q    = {pending_q, r};
    end
    inferences++;
  endfunction

  function automatic void apply_item(logic op, logic [1:0] ls, logic [2:0] ns,
                                     logic [3:0] pos, logic signed [15:0] v,
                                     logic lastf);
    if (op == OP_WEIGHT) begin
      if (pos <= NWIDTH) begin
        weight_mem[ls][ns][pos]  = v;
        weight_seen[ls][ns][pos] = 1'b1;
      end
    end else begin
      if (pos < NWIDTH) begin
        act_bank[0][pos] = v;
        feature_seen[pos] = 1'b1;
      end
      if (lastf) predict_network();
    end
  endfunction

  // Present one transaction; hold it until accepted, then apply it to the predictor.
  task automatic send_item(logic op, logic [1:0] ls, logic [2:0] ns,
                           logic [3:0] pos, logic signed [15:0] v, logic lastf);
    int gap;
    @(negedge clk_i);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst_left--;
    end
    opcode_i       = op;
    layer_sel_i    = ls;
    neuron_sel_i   = ns;
    position_i     = pos;
    value_i        = v;
    last_feature_i = lastf;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_item(op, ls, ns, pos, v, lastf);
    items_sent++;
  endtask

  function automatic logic signed [15:0] rand_q88();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'(int'($urandom_range(0, 4096)) - 2048);
      default: return 16'(int'($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  // Wait out all pending results plus the engine drain, with inputs idle.
  task automatic drain_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic write_config(int nlay, int nin, int w0, int w1, int w2, int w3);
    int vals [6];
    vals = '{nlay, nin, w0, w1, w2, w3};
    drain_idle();
    for (int i = 0; i < 6; i++) begin
      @(negedge clk_i);
      cfg_we_i    = 1'b1;
      cfg_index_i = 3'(i);
      cfg_data_i  = 4'(vals[i]);
      @(posedge clk_i);
      reg_val[i] = 4'(vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Load weights and features needed by the current sizes, mixing in
  // ignored and stray transactions, then fire with a last feature.
  task automatic run_inference(int rewrite_pct, int noise_pct);
    int         nl;
    int         nin;
    int         nout;
    logic [3:0] trig_pos;
    nl  = eff_layers();
    nin = eff_width(reg_val[mlp_pkg::CFG_INPUT_WIDTH]);
    for (int l = 0; l < nl; l++) begin
      nout = layer_neurons(l);
      for (int n = 0; n < nout; n++) begin
        for (int p = 0; p <= nin; p++) begin
          if (!weight_seen[l][n][p] || $urandom_range(0, 99) < rewrite_pct)
            send_item(OP_WEIGHT, 2'(l), 3'(n), 4'(p), rand_q88(),
                      1'($urandom_range(0, 1)));
          if ($urandom_range(0, 99) < noise_pct) begin
            if ($urandom_range(0, 1))
              send_item(OP_WEIGHT, 2'($urandom), 3'($urandom),
                        4'($urandom_range(NWIDTH + 1, 15)), rand_q88(), 1'b0);
            else
              send_item(OP_FEATURE, 2'($urandom), 3'($urandom),
                        4'($urandom_range(NWIDTH, 15)), rand_q88(), 1'b0);
          end
        end
      end
      nin = nout;
    end
    nin = eff_width(reg_val[mlp_pkg::CFG_INPUT_WIDTH]);
    for (int k = 0; k < nin; k++) begin
      if (!feature_seen[k] || $urandom_range(0, 99) < 70)
        send_item(OP_FEATURE, 2'($urandom), 3'($urandom), 4'(k), rand_q88(), 1'b0);
    end
    if ($urandom_range(0, 3) == 0) trig_pos = 4'($urandom_range(NWIDTH, 15));
    else trig_pos = 4'($urandom_range(0, nin - 1));
    send_item(OP_FEATURE, 2'($urandom), 3'($urandom), trig_pos, rand_q88(), 1'b1);
  endtask

  // Reset sizes, one plain inference.
  task automatic test_reset_sizes();
    run_inference(0, 0);
  endtask

  // Full-scale first-layer weights and features at both rails.
  task automatic test_value_extremes();
    logic signed [15:0] rails [2];
    rails = '{16'sh7FFF, 16'sh8000};
    for (int s = 0; s < 2; s++) begin
      for (int n = 0; n < 3; n++) begin
        for (int p = 0; p <= 2; p++)
          send_item(OP_WEIGHT, 2'd0, 3'(n), 4'(p), rails[(n + p + s) % 2], 1'b0);
      end
      send_item(OP_FEATURE, 2'd0, 3'd0, 4'd0, rails[s], 1'b0);
      send_item(OP_FEATURE, 2'd0, 3'd0, 4'd1, rails[1-s], 1'b1);
    end
  endtask

  // Stray addresses, weight with last set, trigger from out-of-range index.
  task automatic test_ignored_items();
    send_item(OP_WEIGHT, 2'd3, 3'd7, 4'd15, 16'sh1234, 1'b1);
    send_item(OP_WEIGHT, 2'd1, 3'd0, 4'd0, 16'sh0100, 1'b1);
    send_item(OP_FEATURE, 2'd3, 3'd7, 4'd8, 16'shFFFF, 1'b0);
    send_item(OP_FEATURE, 2'd0, 3'd0, 4'd15, 16'sh0000, 1'b1);
  endtask

  // Register extremes: zero treated as one, oversize values saturate,
  // the full layer count, and a final layer of eight neurons.
  task automatic test_config_extremes();
    write_config(0, 0, 0, 0, 0, 0);
    run_inference(20, 10);
    write_config(7, 15, 1, 15, 1, 1);
    run_inference(0, 0);
    write_config(4, 2, 2, 2, 2, 1);
    run_inference(10, 0);
    write_config(1, 3, 8, 1, 1, 1);
    run_inference(30, 10);
  endtask

  // Random sizes, mostly small, with random stalls on both sides.
  task automatic test_random_networks();
    int start;
    int nlay;
    start = items_sent;
    while (items_sent - start < 40) begin
      nlay = $urandom_range(1, 4);
      if ($urandom_range(0, 5) == 0)
        write_config($urandom_range(0, 7), $urandom_range(0, 15),
                     $urandom_range(0, 2), $urandom_range(0, 2),
                     $urandom_range(0, 2), $urandom_range(0, 2));
      else
        write_config(nlay, $urandom_range(1, 4), $urandom_range(1, 4),
                     $urandom_range(1, 4), $urandom_range(1, 3),
                     $urandom_range(1, 3));
      sender_gaps = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) run_inference(25, 15);
    end
    sender_gaps = 1'b1;
  endtask

  // Receiver: switch among always-ready, random and periodic stall patterns.
  always @(negedge clk_i) begin
    rx_count <= rx_count + 1;
    if (rx_count % 97 == 0) rx_mode <= $urandom_range(0, 2);
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= (rx_count % 5 == 0);
    endcase
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    neuron_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result index=%0d value=%0d", out_index_o, out_value_o);
        error_count++;
      end else begin
        want = pending_q.pop_front();
        if (out_index_o !== want.index) begin
          $error("out_index expected %0d actual %0d", want.index, out_index_o);
          error_count++;
        end
        if (out_value_o !== want.activation) begin
          $error("out_value expected %0d actual %0d", want.activation, out_value_o);
          error_count++;
        end
        if (out_last_o !== want.last) begin
          $error("out_last expected %0d actual %0d", want.last, out_last_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run after too long without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    build_sigmoid();
    reg_val = '{4'd2, 4'd2, 4'd3, 4'd1, 4'd1, 4'd1};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_sizes();
    test_value_extremes();
    test_ignored_items();
    test_config_extremes();
    test_random_networks();

    // Let the last results and any engine tail drain.
    drain_idle();
    $display("covered %0d transactions, %0d inferences, %0d neuron results",
             items_sent, inferences, results_seen);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
